FILE: hdl/sha1uuid_pkg.sv
package sha1uuid_pkg;

  // Byte source for one absorb step
  typedef enum logic [2:0] {
    BYTE_IN,
    BYTE_HELD,
    BYTE_PREFIX,
    BYTE_PAD80,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic      load_item;
    logic      absorb;
    byte_sel_e sel;
    logic      counted;
    logic [3:0] pre_idx;
    logic      comp_init;
    logic      round;
    logic [6:0] rnd_idx;
    logic      comp_fin;
    logic      clear;
    logic      uuid;
    logic [2:0] word_idx;
  } cmd_t;

  localparam logic [31:0] INIT_WORDS [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] NS_PREFIX [16] = '{
    8'h6b, 8'h2e, 8'h8a, 8'h14, 8'h9d, 8'h37, 8'h4c, 8'h55,
    8'hb1, 8'h0e, 8'ha2, 8'h7f, 8'h3d, 8'hc9, 8'h18, 8'h40
  };

  localparam logic [31:0] K_G0 = 32'h5A827999;
  localparam logic [31:0] K_G1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_G2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_G3 = 32'hCA62C1D6;

  localparam logic [6:0] FILL_LAST    = 7'd63;
  localparam logic [6:0] FILL_PAD_END = 7'd56;
  localparam logic [6:0] ROUND_G1     = 7'd20;
  localparam logic [6:0] ROUND_G2     = 7'd40;
  localparam logic [6:0] ROUND_G3     = 7'd60;
  localparam logic [6:0] ROUND_LAST   = 7'd79;
  localparam logic [3:0] PREFIX_LAST  = 4'd15;
  localparam logic [2:0] WORD_LAST_UUID = 3'd3;
  localparam logic [2:0] WORD_LAST_SHA  = 3'd4;

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [3:0] UUID_VERSION = 4'h5;
  localparam logic [1:0] UUID_VARIANT = 2'b10;

endpackage

FILE: hdl/sha1uuid_ctrl.sv
module sha1uuid_ctrl
  import sha1uuid_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic       s_byte_valid_i,
  input  logic       s_end_i,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output logic       m_last_o,
  input  logic       cfg_valid_i,
  input  logic       cfg_data_i,
  output logic       cfg_ready_o,
  input  logic [6:0] fill_i,
  output cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREFIX = 4'd1;
  localparam logic [3:0] S_DATA   = 4'd2;
  localparam logic [3:0] S_PAD    = 4'd3;
  localparam logic [3:0] S_ZERO   = 4'd4;
  localparam logic [3:0] S_LEN    = 4'd5;
  localparam logic [3:0] S_ROUND  = 4'd6;
  localparam logic [3:0] S_CFIN   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0] state_q, state_d;
  logic [3:0] ret_q, ret_d;
  logic       start_q, start_d;
  logic       valid_q, valid_d;
  logic       end_q, end_d;
  logic [3:0] pre_q, pre_d;
  logic [6:0] rnd_q, rnd_d;
  logic [2:0] word_q, word_d;
  logic       mode_q;
  logic       take;
  logic [3:0] after;
  logic       last;

  assign cfg_ready_o = 1'b1;
  assign s_ready_o   = (state_q == S_IDLE);
  assign m_valid_o   = (state_q == S_OUT);
  assign last        = (word_q == (mode_q ? WORD_LAST_UUID : WORD_LAST_SHA));
  assign m_last_o    = last;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    start_d = start_q;
    valid_d = valid_q;
    end_d   = end_q;
    pre_d   = pre_q;
    rnd_d   = rnd_q;
    word_d  = word_q;
    take    = 1'b0;
    after   = state_q;
    cmd_o          = '0;
    cmd_o.sel      = BYTE_ZERO;
    cmd_o.uuid     = mode_q;
    cmd_o.pre_idx  = pre_q;
    cmd_o.rnd_idx  = rnd_q;
    cmd_o.word_idx = word_q;

    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          start_d         = 1'b0;
          valid_d         = s_byte_valid_i;
          end_d           = s_end_i;
          cmd_o.load_item = 1'b1;
          if (start_q && mode_q) begin
            pre_d   = '0;
            state_d = S_PREFIX;
          end else begin
            after = s_end_i ? S_PAD : S_IDLE;
            if (s_byte_valid_i) begin
              take          = 1'b1;
              cmd_o.sel     = BYTE_IN;
              cmd_o.counted = 1'b1;
            end else begin
              state_d = after;
            end
          end
        end
      end
      S_PREFIX: begin
        take          = 1'b1;
        cmd_o.sel     = BYTE_PREFIX;
        cmd_o.counted = 1'b1;
        pre_d         = pre_q + 4'd1;
        if (pre_q == PREFIX_LAST) begin
          after = valid_q ? S_DATA : (end_q ? S_PAD : S_IDLE);
        end else begin
          after = S_PREFIX;
        end
      end
      S_DATA: begin
        take          = 1'b1;
        cmd_o.sel     = BYTE_HELD;
        cmd_o.counted = 1'b1;
        after         = end_q ? S_PAD : S_IDLE;
      end
      S_PAD: begin
        take      = 1'b1;
        cmd_o.sel = BYTE_PAD80;
        after     = S_ZERO;
      end
      S_ZERO: begin
        if (fill_i == FILL_PAD_END) begin
          state_d = S_LEN;
        end else begin
          take      = 1'b1;
          cmd_o.sel = BYTE_ZERO;
          after     = S_ZERO;
        end
      end
      S_LEN: begin
        take      = 1'b1;
        cmd_o.sel = BYTE_LEN;
        after     = (fill_i == FILL_LAST) ? S_OUT : S_LEN;
      end
      S_ROUND: begin
        cmd_o.round = 1'b1;
        rnd_d       = rnd_q + 7'd1;
        if (rnd_q == ROUND_LAST) begin
          state_d = S_CFIN;
        end
      end
      S_CFIN: begin
        cmd_o.comp_fin = 1'b1;
        state_d        = ret_q;
      end
      S_OUT: begin
        if (m_ready_i) begin
          if (last) begin
            cmd_o.clear = 1'b1;
            start_d     = 1'b1;
            word_d      = '0;
            state_d     = S_IDLE;
          end else begin
            word_d = word_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A byte that fills the block starts compression right away
    cmd_o.absorb = take;
    if (take) begin
      if (fill_i == FILL_LAST) begin
        cmd_o.comp_init = 1'b1;
        rnd_d           = '0;
        ret_d           = after;
        state_d         = S_ROUND;
      end else begin
        state_d = after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      start_q <= 1'b1;
      valid_q <= 1'b0;
      end_q   <= 1'b0;
      pre_q   <= '0;
      rnd_q   <= '0;
      word_q  <= '0;
      mode_q  <= 1'b1;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      start_q <= start_d;
      valid_q <= valid_d;
      end_q   <= end_d;
      pre_q   <= pre_d;
      rnd_q   <= rnd_d;
      word_q  <= word_d;
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
    end
  end

endmodule

FILE: hdl/sha1uuid_dp.sv
module sha1uuid_dp
  import sha1uuid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  data_i,
  output logic [6:0]  fill_o,
  output logic [31:0] word_o
);

  logic [511:0] buf_q;
  logic [7:0]   held_q;
  logic [6:0]   fill_q;
  logic [60:0]  msg_q;
  logic [31:0]  chain_q [5];
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;

  logic [7:0]  byte_val;
  logic [63:0] bit_len;
  logic [2:0]  len_idx;
  logic [31:0] w_cur, w_mix, w_new;
  logic [31:0] f_val, k_val, t_val;
  logic [31:0] chain_sel;

  assign fill_o  = fill_q;
  assign bit_len = {msg_q, 3'b000};
  assign len_idx = ~fill_q[2:0];

  always_comb begin
    case (cmd_i.sel)
      BYTE_IN:     byte_val = data_i;
      BYTE_HELD:   byte_val = held_q;
      BYTE_PREFIX: byte_val = NS_PREFIX[cmd_i.pre_idx];
      BYTE_PAD80:  byte_val = PAD_BYTE;
      BYTE_LEN:    byte_val = bit_len[{len_idx, 3'b000} +: 8];
      default:     byte_val = 8'h00;
    endcase
  end

  // Schedule taps: slot j of the window sits at bits [511-32j -: 32]
  assign w_cur = buf_q[511:480];
  assign w_mix = buf_q[95:64] ^ buf_q[255:224] ^ buf_q[447:416] ^ w_cur;
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (cmd_i.rnd_idx < ROUND_G1) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = K_G0;
    end else if (cmd_i.rnd_idx < ROUND_G2) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_G1;
    end else if (cmd_i.rnd_idx < ROUND_G3) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = K_G2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = K_G3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;

  always_comb begin
    case (cmd_i.word_idx)
      3'd0:    chain_sel = chain_q[0];
      3'd1:    chain_sel = chain_q[1];
      3'd2:    chain_sel = chain_q[2];
      3'd3:    chain_sel = chain_q[3];
      3'd4:    chain_sel = chain_q[4];
      default: chain_sel = chain_q[0];
    endcase
    word_o = chain_sel;
    if (cmd_i.uuid && cmd_i.word_idx == 3'd1) begin
      word_o = {chain_sel[31:16], UUID_VERSION, chain_sel[11:0]};
    end
    if (cmd_i.uuid && cmd_i.word_idx == 3'd2) begin
      word_o = {UUID_VARIANT, chain_sel[29:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      held_q <= data_i;
    end
    if (cmd_i.absorb) begin
      buf_q <= {buf_q[503:0], byte_val};
    end else if (cmd_i.round) begin
      buf_q <= {buf_q[479:0], w_new};
    end
    if (cmd_i.comp_init) begin
      a_q <= chain_q[0];
      b_q <= chain_q[1];
      c_q <= chain_q[2];
      d_q <= chain_q[3];
      e_q <= chain_q[4];
    end else if (cmd_i.round) begin
      a_q <= t_val;
      b_q <= a_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      d_q <= c_q;
      e_q <= d_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      msg_q  <= '0;
      for (int i = 0; i < 5; i++) begin
        chain_q[i] <= INIT_WORDS[i];
      end
    end else begin
      if (cmd_i.clear) begin
        fill_q <= '0;
        msg_q  <= '0;
        for (int i = 0; i < 5; i++) begin
          chain_q[i] <= INIT_WORDS[i];
        end
      end else begin
        if (cmd_i.comp_fin) begin
          fill_q     <= '0;
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
          chain_q[4] <= chain_q[4] + e_q;
        end else if (cmd_i.absorb) begin
          fill_q <= fill_q + 7'd1;
        end
        if (cmd_i.absorb && cmd_i.counted) begin
          msg_q <= msg_q + 61'd1;
        end
      end
    end
  end

endmodule

FILE: hdl/sha1_name_based_uuid.sv
// Channel  Direction  Handshake                     Payload
// s_axis   in         s_axis_tvalid/s_axis_tready   tdata message byte, tuser byte valid,
//                                                   tlast end of message
// m_axis   out        m_axis_tvalid/m_axis_tready   tdata digest word and index, tlast last
// cfg      in         cfg_valid_i/cfg_ready_o       cfg_data_i uuid mode (reset 1)
//
// An item carrying a byte is absorbed into the block buffer; each full 64-byte
// block is compressed in 80 rounds on the single round unit plus the chain update.
// In mode 1 the first item of a message is preceded by the 16-byte namespace
// prefix, then its held byte, if any, is absorbed. At end of message, the pad byte,
// zero bytes and the 64-bit bit length are absorbed, then 4 or 5 output transfers follow.
// Reset is asynchronous; no clearing pass is needed. Input is held off
// while the block is busy or while a result waits for the sink.
module sha1_name_based_uuid
  import sha1uuid_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Message input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tuser,   // [0] byte_valid
  input  logic        s_axis_tlast,   // end_of_message
  // Digest output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_axis_tlast,   // last_word
  // Mode register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i      // uuid_mode
);

  cmd_t        cmd;
  logic [6:0]  fill;
  logic [31:0] word;

  // Sequence absorb, padding, compression and output steps
  sha1uuid_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid),
    .s_ready_o      (s_axis_tready),
    .s_byte_valid_i (s_axis_tuser),
    .s_end_i        (s_axis_tlast),
    .m_valid_o      (m_axis_tvalid),
    .m_ready_i      (m_axis_tready),
    .m_last_o       (m_axis_tlast),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .cfg_ready_o    (cfg_ready_o),
    .fill_i         (fill),
    .cmd_o          (cmd)
  );

  // Block buffer, message schedule, round unit and chaining words
  sha1uuid_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .data_i (s_axis_tdata),
    .fill_o (fill),
    .word_o (word)
  );

  // Hold the word steady while the sink stalls: chain and index do not move
  assign m_axis_tdata = {5'b00000, cmd.word_idx, word};

endmodule
